@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// when the trigger holds, the result must hold in the next cycle
`define ASSERT_NEXT(label, clk, rst, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`endif

@@ sv/mlm_pkg.sv @@
// ----------------------------------------------------------------------------
// mlm_pkg
// types and codes shared by the fifo hand-off mutex modules
// ----------------------------------------------------------------------------
package mlm_pkg;

  typedef logic [7:0] tid_t;

  typedef enum logic [1:0] {
    REQ_LOCK    = 2'd0,
    REQ_UNLOCK  = 2'd1,
    REQ_TRYLOCK = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_BUSY      = 3'd2,
    ST_OWNER     = 3'd3,
    ST_NOT_OWNER = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0] req_type;
    tid_t       thread_id;
  } in_item_t;

  typedef struct packed {
    status_t status;
    logic    woken_valid;
    tid_t    woken_id;
    logic    is_locked;
    tid_t    owner_id;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

@@ sv/mutex_lock_manager.sv @@
// result beat: the request is captured into the request register, then the
//   execute state commits the result once the output register is free; a new
//   request is taken only after that, and execute uses the registered head read
// reset: synchronous; mutex free, owner 0, queue empty; queue memory is not
//   cleared, entries are only read after being written
// ----------------------------------------------------------------------------
// mutex_lock_manager
// fifo hand-off mutex with owner register and queue of waiting thread ids
// ----------------------------------------------------------------------------
module mutex_lock_manager #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mlm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output mlm_pkg::out_item_t out_item
);

  mlm_pkg::cmd_t cmd;

  mlm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  mlm_datapath #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

@@ sv/mlm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mlm_ctrl
// sequencer: takes a request beat, stays in the execute state until the
// result can enter the output register, and holds it there until it is taken
// ----------------------------------------------------------------------------
module mlm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output mlm_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   commit;

  assign in_ready    = (state == S_IDLE);
  // a new result may enter when the output register is empty or being drained
  assign commit      = (state == S_EXEC) && (!out_valid || out_ready);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.commit  = commit;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    priority if (commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ sv/mlm_datapath.sv @@
// ----------------------------------------------------------------------------
// mlm_datapath
// request register, owner and lock flag, wait queue memory with head and tail
// pointers and wait count, and the result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlm_datapath #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  mlm_pkg::cmd_t      cmd,
  input  mlm_pkg::in_item_t  in_item,
  output mlm_pkg::out_item_t out_item
);

  // ids are never wider than the 8-bit field
  localparam int IdW  = (THREAD_ID_BITS < 8) ? THREAD_ID_BITS : 8;
  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [IdW-1:0]  wait_mem [QUEUE_DEPTH];
  logic [IdW-1:0]  rd_data;

  mlm_pkg::req_t   req_q;
  logic [IdW-1:0]  tid_q;

  logic            lock_flag;
  logic            lock_flag_next;
  logic [IdW-1:0]  owner;
  logic [IdW-1:0]  owner_next;
  logic [PtrW-1:0] head_ptr;
  logic [PtrW-1:0] tail_ptr;
  logic [CntW-1:0] wait_count;

  logic               do_push;
  logic               do_pop;
  mlm_pkg::out_item_t res;
  mlm_pkg::out_item_t out_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= mlm_pkg::req_t'(in_item.req_type);
      tid_q <= IdW'(in_item.thread_id);
    end
  end

  // queue memory, head entry read every cycle
  always_ff @(posedge clk) begin
    if (do_push) wait_mem[tail_ptr] <= tid_q;
    rd_data <= wait_mem[head_ptr];
  end

  always_comb begin
    lock_flag_next  = lock_flag;
    owner_next      = owner;
    do_push         = 1'b0;
    do_pop          = 1'b0;
    res.status      = mlm_pkg::ST_NOT_OWNER;
    res.woken_valid = 1'b0;
    res.woken_id    = '0;
    unique case (req_q)
      mlm_pkg::REQ_LOCK: begin
        priority if (!lock_flag) begin
          lock_flag_next = 1'b1;
          owner_next     = tid_q;
          res.status     = mlm_pkg::ST_GRANTED;
        end else if (owner == tid_q) begin
          res.status = mlm_pkg::ST_OWNER;
        end else if (wait_count == CntW'(QUEUE_DEPTH)) begin
          res.status = mlm_pkg::ST_FULL;
        end else begin
          do_push    = cmd.commit;
          res.status = mlm_pkg::ST_QUEUED;
        end
      end
      mlm_pkg::REQ_UNLOCK: begin
        if (lock_flag && owner == tid_q) begin
          if (wait_count != '0) begin
            // hand over to the oldest waiter
            do_pop          = cmd.commit;
            owner_next      = rd_data;
            res.woken_valid = 1'b1;
            res.woken_id    = mlm_pkg::tid_t'(rd_data);
          end else begin
            lock_flag_next = 1'b0;
            owner_next     = '0;
          end
          res.status = mlm_pkg::ST_GRANTED;
        end
      end
      mlm_pkg::REQ_TRYLOCK: begin
        if (!lock_flag) begin
          lock_flag_next = 1'b1;
          owner_next     = tid_q;
          res.status     = mlm_pkg::ST_GRANTED;
        end else begin
          res.status = mlm_pkg::ST_BUSY;
        end
      end
      default: res.status = mlm_pkg::ST_NOT_OWNER;
    endcase
    res.is_locked = lock_flag_next;
    res.owner_id  = lock_flag_next ? mlm_pkg::tid_t'(owner_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_flag  <= 1'b0;
      owner      <= '0;
      head_ptr   <= '0;
      tail_ptr   <= '0;
      wait_count <= '0;
    end else if (cmd.commit) begin
      lock_flag <= lock_flag_next;
      owner     <= owner_next;
      if (do_push) begin
        tail_ptr   <= ptr_inc(tail_ptr);
        wait_count <= wait_count + 1'b1;
      end
      if (do_pop) begin
        head_ptr   <= ptr_inc(head_ptr);
        wait_count <= wait_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_q <= res;
  end

  assign out_item = out_q;

  `ASSERT_ALWAYS(a_count_bound, clk, rst, wait_count <= CntW'(QUEUE_DEPTH), "wait count overflow")
  `ASSERT_ALWAYS(a_free_no_waiters, clk, rst, lock_flag || wait_count == '0, "waiters on free mutex")
  `ASSERT_ALWAYS(a_push_pop_excl, clk, rst, !(do_push && do_pop), "push and pop together")
  `ASSERT_NEXT(a_handoff_owner, clk, rst, cmd.commit, !out_q.woken_valid || (out_q.is_locked && out_q.owner_id == out_q.woken_id), "woken id is not new owner")

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the fifo hand-off mutex: directed table, then random
// lock/unlock/trylock/unused-code requests mostly from a small thread pool;
// typed rows vs. the table, all else vs. a cycle-free model of owner and queue
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int        QDEPTH      = 16;
  localparam int        RAND_ITEMS  = 750;
  localparam int        CYCLE_LIMIT = 200000;
  localparam int        DRAIN       = 8;
  localparam int        HOLD_CYCLES = 80;
  localparam logic [1:0] REQ_BAD    = 2'd3;

  typedef struct {
    mlm_pkg::in_item_t  item;
    bit                 typed;
    mlm_pkg::out_item_t want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  mlm_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  mlm_pkg::out_item_t out_item;

  // model state
  bit                 mdl_locked;
  mlm_pkg::tid_t      mdl_owner;
  mlm_pkg::tid_t      mdl_waiters [QDEPTH];
  int                 mdl_head, mdl_tail, mdl_count;

  mlm_pkg::out_item_t pending_results[$];
  dir_row_t           dir_rows[$];
  bit                 row_typed = 1'b0;
  mlm_pkg::out_item_t row_want = '0;
  bit                 calm = 1'b0;
  bit                 stall_req = 1'b0;
  int                 hold_left = 0;
  int                 err_count = 0;
  int                 sent_count = 0;
  int                 result_count = 0;
  int                 status_seen [8];
  int                 cycle_count = 0;

  mutex_lock_manager uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic mlm_pkg::out_item_t mutex_step(mlm_pkg::in_item_t rq);
    mlm_pkg::out_item_t r;
    mlm_pkg::tid_t      id;
    r = '0;
    r.status = mlm_pkg::ST_NOT_OWNER;
    id = rq.thread_id;
    case (rq.req_type)
      mlm_pkg::REQ_LOCK: begin
        if (!mdl_locked) begin
          mdl_locked = 1'b1;
          mdl_owner = id;
          r.status = mlm_pkg::ST_GRANTED;
        end else if (mdl_owner == id) begin
          r.status = mlm_pkg::ST_OWNER;
        end else if (mdl_count >= QDEPTH) begin
          r.status = mlm_pkg::ST_FULL;
        end else begin
          mdl_waiters[mdl_tail] = id;
          mdl_tail = (mdl_tail + 1) % QDEPTH;
          mdl_count++;
          r.status = mlm_pkg::ST_QUEUED;
        end
      end
      mlm_pkg::REQ_UNLOCK: begin
        if (mdl_locked && mdl_owner == id) begin
          if (mdl_count > 0) begin
            r.woken_valid = 1'b1;
            r.woken_id = mdl_waiters[mdl_head];
            mdl_owner = mdl_waiters[mdl_head];
            mdl_head = (mdl_head + 1) % QDEPTH;
            mdl_count--;
          end else begin
            mdl_locked = 1'b0;
            mdl_owner = '0;
          end
          r.status = mlm_pkg::ST_GRANTED;
        end
      end
      mlm_pkg::REQ_TRYLOCK: begin
        if (!mdl_locked) begin
          mdl_locked = 1'b1;
          mdl_owner = id;
          r.status = mlm_pkg::ST_GRANTED;
        end else begin
          r.status = mlm_pkg::ST_BUSY;
        end
      end
      default: ;
    endcase
    r.is_locked = mdl_locked;
    r.owner_id = mdl_locked ? mdl_owner : '0;
    return r;
  endfunction

  // request and result beats, sampled at the rising edge
  always @(posedge clk) begin
    mlm_pkg::out_item_t want;
    mlm_pkg::out_item_t pred;
    if (!rst) begin
      if (out_valid && out_ready) begin
        result_count++;
        status_seen[int'(out_item.status)]++;
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %p", $time, out_item);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_item.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, out_item.status);
            err_count++;
          end
          if (out_item.woken_valid !== want.woken_valid) begin
            $display("%0t: woken_valid exp %0d got %0d", $time, want.woken_valid,
                     out_item.woken_valid);
            err_count++;
          end
          if (out_item.woken_id !== want.woken_id) begin
            $display("%0t: woken_id exp %0d got %0d", $time, want.woken_id,
                     out_item.woken_id);
            err_count++;
          end
          if (out_item.is_locked !== want.is_locked) begin
            $display("%0t: is_locked exp %0d got %0d", $time, want.is_locked,
                     out_item.is_locked);
            err_count++;
          end
          if (out_item.owner_id !== want.owner_id) begin
            $display("%0t: owner_id exp %0d got %0d", $time, want.owner_id,
                     out_item.owner_id);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        sent_count++;
        pred = mutex_step(in_item);
        pending_results.push_back(row_typed ? row_want : pred);
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (stall_req) begin
      stall_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 16);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("TB_ERROR");
    $finish;
  end

  task automatic offer(input mlm_pkg::in_item_t it, input bit typed,
                       input mlm_pkg::out_item_t want);
    if (!calm && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void add_row(logic [1:0] rq, mlm_pkg::tid_t id, bit typed,
                                  mlm_pkg::status_t st, logic wv, mlm_pkg::tid_t wid,
                                  logic lk, mlm_pkg::tid_t own);
    dir_row_t row;
    row.item.req_type = rq;
    row.item.thread_id = id;
    row.typed = typed;
    row.want.status = st;
    row.want.woken_valid = wv;
    row.want.woken_id = wid;
    row.want.is_locked = lk;
    row.want.owner_id = own;
    dir_rows.push_back(row);
  endfunction

  function automatic mlm_pkg::in_item_t next_request(int lock_wt);
    mlm_pkg::in_item_t it;
    int                roll;
    roll = $urandom_range(0, 99);
    it.thread_id = ($urandom_range(0, 99) < 70) ? mlm_pkg::tid_t'($urandom_range(0, 7))
                                                : mlm_pkg::tid_t'($urandom_range(0, 255));
    if (roll < 3) begin
      it.req_type = REQ_BAD;
    end else if (roll < 3 + lock_wt) begin
      it.req_type = mlm_pkg::REQ_LOCK;
    end else if (roll < 15 + lock_wt) begin
      it.req_type = mlm_pkg::REQ_TRYLOCK;
    end else begin
      it.req_type = mlm_pkg::REQ_UNLOCK;
      // mostly the real owner, so hand-offs keep the queue moving
      if (mdl_locked && $urandom_range(0, 99) < 85)
        it.thread_id = mdl_owner;
    end
    return it;
  endfunction

  initial begin
    int lock_wt;
    // free mutex, unlock by leftover owner value
    add_row(mlm_pkg::REQ_UNLOCK, 8'd0, 1'b1, mlm_pkg::ST_NOT_OWNER, 1'b0, 8'd0, 1'b0, 8'd0);
    add_row(mlm_pkg::REQ_TRYLOCK, 8'd255, 1'b1, mlm_pkg::ST_GRANTED, 1'b0, 8'd0, 1'b1,
            8'd255);
    // trylock by the owner reports busy
    add_row(mlm_pkg::REQ_TRYLOCK, 8'd255, 1'b1, mlm_pkg::ST_BUSY, 1'b0, 8'd0, 1'b1, 8'd255);
    add_row(mlm_pkg::REQ_LOCK, 8'd255, 1'b1, mlm_pkg::ST_OWNER, 1'b0, 8'd0, 1'b1, 8'd255);
    add_row(mlm_pkg::REQ_UNLOCK, 8'd0, 1'b1, mlm_pkg::ST_NOT_OWNER, 1'b0, 8'd0, 1'b1,
            8'd255);
    // unused request code is ignored even from the owner
    add_row(REQ_BAD, 8'd255, 1'b1, mlm_pkg::ST_NOT_OWNER, 1'b0, 8'd0, 1'b1, 8'd255);
    // same waiter queued twice
    add_row(mlm_pkg::REQ_LOCK, 8'd0, 1'b1, mlm_pkg::ST_QUEUED, 1'b0, 8'd0, 1'b1, 8'd255);
    add_row(mlm_pkg::REQ_LOCK, 8'd0, 1'b1, mlm_pkg::ST_QUEUED, 1'b0, 8'd0, 1'b1, 8'd255);
    for (int i = 1; i <= 14; i++)
      add_row(mlm_pkg::REQ_LOCK, mlm_pkg::tid_t'(i), 1'b0, mlm_pkg::ST_QUEUED, 1'b0, 8'd0,
              1'b1, 8'd255);
    add_row(mlm_pkg::REQ_LOCK, 8'd128, 1'b1, mlm_pkg::ST_FULL, 1'b0, 8'd0, 1'b1, 8'd255);
    // hand-offs to the oldest waiters
    add_row(mlm_pkg::REQ_UNLOCK, 8'd255, 1'b1, mlm_pkg::ST_GRANTED, 1'b1, 8'd0, 1'b1, 8'd0);
    add_row(mlm_pkg::REQ_UNLOCK, 8'd0, 1'b1, mlm_pkg::ST_GRANTED, 1'b1, 8'd0, 1'b1, 8'd0);

    mdl_locked = 1'b0;
    mdl_owner = '0;
    mdl_head = 0;
    mdl_tail = 0;
    mdl_count = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i])
      offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    lock_wt = 40;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0)
        lock_wt = $urandom_range(15, 70);
      calm = (n >= 350 && n < 450);
      if (n == 150)
        stall_req = 1'b1;
      if (n == 600) begin
        // let everything drain before carrying on
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      offer(next_request(lock_wt), 1'b0, '0);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("%0d requests, %0d results: %0d granted, %0d queued, %0d busy, %0d owner",
             sent_count, result_count, status_seen[mlm_pkg::ST_GRANTED],
             status_seen[mlm_pkg::ST_QUEUED], status_seen[mlm_pkg::ST_BUSY],
             status_seen[mlm_pkg::ST_OWNER]);
    $display("  %0d not-owner, %0d queue full; %0d mismatches",
             status_seen[mlm_pkg::ST_NOT_OWNER], status_seen[mlm_pkg::ST_FULL], err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
